@@ hdl/rtpm_pkg.sv @@
// Shared types and codes for the route table prefix match block.
// No dependencies; imported by rtpm_cell and route_table_prefix_match_top.
package rtpm_pkg;

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DUP      = 3'd1;
    localparam logic [2:0] STAT_UNREACH  = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_DIRECT   = 3'd4;
    localparam logic [2:0] STAT_NOTFOUND = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_PORT_A_ADDR    = 2'd0;
    localparam logic [1:0] CFG_PORT_A_NETMASK = 2'd1;
    localparam logic [1:0] CFG_PORT_B_ADDR    = 2'd2;
    localparam logic [1:0] CFG_PORT_B_NETMASK = 2'd3;

    // One stored route, also used for the command operands
    typedef struct packed {
        logic [31:0] mask;
        logic [31:0] dest;
        logic [31:0] hop;
    } route_t;

    // Running result handed from cell to cell
    typedef struct packed {
        logic        found;  // some route matched the lookup so far
        logic [31:0] best;   // mask of the current best match
        logic [31:0] fwd;    // forward address of the current best match
        logic        dup;    // an identical route was seen so far
        logic        hit;    // an identical user entry was seen so far
    } token_t;

endpackage

@@ hdl/route_table_prefix_match_top.sv @@
// Route table prefix match, top level: a chain of TABLE_DEPTH cells and its sequencer.
// An item is accepted, swept down the chain, then held in the done state until the output is
// free, when its result is registered; the next item is accepted only after that, so items never overlap.
// The sweep is paced by the result token moving one cell per cycle down the chain.
// Reset (aresetn low, synchronous) clears the fill count, the sequencer, the output valid
// and the interface registers; stored routes are undefined until written.
module route_table_prefix_match_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // cmd[1:0], dest_addr[33:2], route_netmask[65:34],
                                    // hop_addr[97:66], zero pad[103:98]
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // status[2:0], route_found[3], forward_addr[35:4],
                                    // zero pad[39:36]
    // Configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import rtpm_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    cmd_reg;
    route_t        query_reg;

    logic [31:0] port_a_addr_reg, port_a_netmask_reg;
    logic [31:0] port_b_addr_reg, port_b_netmask_reg;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [2:0]  status_reg, status_next;
    logic        found_reg, found_next;
    logic [31:0] fwd_reg, fwd_next;

    token_t tok_chain [TABLE_DEPTH+1];
    route_t entries   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] active;
    logic [TABLE_DEPTH-1:0] wr_en;
    logic [TABLE_DEPTH-1:0] sh_en;

    logic   s_xfer;
    logic   finish;
    logic   do_add;
    logic   do_del;
    logic   match_a, match_b;
    logic   unreach;
    token_t head_tok;
    token_t tail;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_a_addr_reg    <= 32'd0;
            port_a_netmask_reg <= 32'd0;
            port_b_addr_reg    <= 32'd0;
            port_b_netmask_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PORT_A_ADDR:    port_a_addr_reg    <= cfg_data;
                CFG_PORT_A_NETMASK: port_a_netmask_reg <= cfg_data;
                CFG_PORT_B_ADDR:    port_b_addr_reg    <= cfg_data;
                CFG_PORT_B_NETMASK: port_b_netmask_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Command capture on input transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg        <= s_tdata[1:0];
            query_reg.dest <= s_tdata[33:2];
            query_reg.mask <= s_tdata[65:34];
            query_reg.hop  <= s_tdata[97:66];
        end
    end

    // Head token: the two direct routes, port A first
    always_comb begin
        match_a = ((query_reg.dest & port_a_netmask_reg) ==
                   (port_a_addr_reg & port_a_netmask_reg));
        match_b = ((query_reg.dest & port_b_netmask_reg) ==
                   (port_b_addr_reg & port_b_netmask_reg));
        head_tok.found = match_a | match_b;
        head_tok.best  = 32'd0;
        head_tok.fwd   = 32'd0;
        if (match_a) begin
            head_tok.best = port_a_netmask_reg;
            head_tok.fwd  = query_reg.dest;
        end
        if (match_b && (!match_a || (port_b_netmask_reg >= port_a_netmask_reg))) begin
            head_tok.best = port_b_netmask_reg;
            head_tok.fwd  = query_reg.dest;
        end
        head_tok.dup =
            ((port_a_netmask_reg == query_reg.mask) &&
             ((port_a_addr_reg & port_a_netmask_reg) == query_reg.dest) &&
             (query_reg.hop == 32'd0)) ||
            ((port_b_netmask_reg == query_reg.mask) &&
             ((port_b_addr_reg & port_b_netmask_reg) == query_reg.dest) &&
             (query_reg.hop == 32'd0));
        head_tok.hit = 1'b0;
    end

    assign tok_chain[0] = head_tok;

    // Cell chain
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        route_t sh_src;
        if (k == TABLE_DEPTH - 1) begin : g_last
            assign sh_src = entries[k];
        end else begin : g_mid
            assign sh_src = entries[k+1];
        end

        assign active[k] = (CW'(k) < count_reg);
        assign wr_en[k]  = do_add && (count_reg == CW'(k));
        assign sh_en[k]  = do_del && tok_chain[k+1].hit;

        rtpm_cell u_cell (
            .aclk    (aclk),
            .active  (active[k]),
            .query   (query_reg),
            .tok_in  (tok_chain[k]),
            .tok_out (tok_chain[k+1]),
            .wr_en   (wr_en[k]),
            .wr_data (query_reg),
            .sh_en   (sh_en[k]),
            .sh_data (sh_src),
            .entry   (entries[k])
        );
    end

    assign tail    = tok_chain[TABLE_DEPTH];
    assign finish  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign unreach = ((port_a_netmask_reg & query_reg.hop) !=
                      (port_a_netmask_reg & port_a_addr_reg)) &&
                     ((port_b_netmask_reg & query_reg.hop) !=
                      (port_b_netmask_reg & port_b_addr_reg));

    // Result and table update decisions
    always_comb begin
        do_add      = 1'b0;
        do_del      = 1'b0;
        status_next = STAT_OK;
        found_next  = 1'b0;
        fwd_next    = 32'd0;
        count_next  = count_reg;
        unique case (cmd_reg)
            CMD_LOOKUP: begin
                found_next = tail.found;
                fwd_next   = tail.found ? tail.fwd : 32'd0;
            end
            CMD_ADD: begin
                priority if (tail.dup) begin
                    status_next = STAT_DUP;
                end else if (unreach) begin
                    status_next = STAT_UNREACH;
                end else if (count_reg >= CW'(TABLE_DEPTH)) begin
                    status_next = STAT_FULL;
                end else begin
                    do_add     = finish;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DELETE: begin
                priority if (query_reg.hop == 32'd0) begin
                    status_next = STAT_DIRECT;
                end else if (tail.hit) begin
                    do_del     = finish;
                    count_next = count_reg - CW'(1);
                end else begin
                    status_next = STAT_NOTFOUND;
                end
            end
            CMD_NONE: ;
            default:  ;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                step_next = '0;
                if (s_xfer) begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP: begin
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(TABLE_DEPTH - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (finish) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            if (finish) begin
                count_reg <= count_next;
            end
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (finish) begin
            status_reg <= status_next;
            found_reg  <= found_next;
            fwd_reg    <= fwd_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, fwd_reg, found_reg, status_reg};

`ifndef SYNTHESIS
    // Fill count never exceeds the table depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // An accepted item always starts a sweep
    a_accept_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_SWEEP))
        else $error("accepted item did not start a sweep");

    // A new result appears only when a sweep completes
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    // Fill count changes only on completion of an item
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> $past(state_reg == S_DONE))
        else $error("fill count changed mid sweep");
`endif

endmodule

@@ hdl/rtpm_cell.sv @@
// One table cell: holds a user route and updates the running result token.
// Depends on rtpm_pkg (route_t, token_t).
module rtpm_cell (
    input  logic            aclk,
    input  logic            active,    // this entry lies below the fill count
    input  rtpm_pkg::route_t query,    // operands of the command in progress
    input  rtpm_pkg::token_t tok_in,   // token from the previous cell
    output rtpm_pkg::token_t tok_out,  // registered token to the next cell
    input  logic            wr_en,     // append a route here
    input  rtpm_pkg::route_t wr_data,
    input  logic            sh_en,     // take the entry of the next cell
    input  rtpm_pkg::route_t sh_data,
    output rtpm_pkg::route_t entry     // stored route, to the previous cell
);
    import rtpm_pkg::*;

    route_t entry_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   lpm_match;
    logic   same_route;

    // Compare this entry against the query
    always_comb begin
        lpm_match  = active && ((query.dest & entry_reg.mask) == entry_reg.dest) &&
                     (!tok_in.found || (entry_reg.mask >= tok_in.best));
        same_route = active && (entry_reg.mask == query.mask) &&
                     (entry_reg.dest == query.dest) && (entry_reg.hop == query.hop);
        tok_next   = tok_in;
        if (lpm_match) begin
            tok_next.found = 1'b1;
            tok_next.best  = entry_reg.mask;
            tok_next.fwd   = (entry_reg.hop == 32'd0) ? query.dest : entry_reg.hop;
        end
        tok_next.dup = tok_in.dup | same_route;
        tok_next.hit = tok_in.hit | same_route;
    end

    // Token stage toward the next cell
    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    // Entry storage: append or shift up on delete
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_data;
        end else if (sh_en) begin
            entry_reg <= sh_data;
        end
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

endmodule

@@ verif/tb_route_table_prefix_match_top.sv @@
// Self-checking testbench for route_table_prefix_match_top: directed rows, then random phases.
// Each result is checked against an in-bench route table predictor or a directed row's result.
// Depends on rtpm_pkg and the route_table_prefix_match_top RTL.
`timescale 1ns / 1ps

module tb_route_table_prefix_match_top;
    import rtpm_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int LATENCY        = TABLE_DEPTH + 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 45;

    // One result as carried on m_tdata
    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] fwd;
    } reply_t;

    // One row of the directed table: a register write or a command
    typedef struct {
        logic        is_cfg;
        logic [1:0]  cfg_idx;
        logic [31:0] cfg_val;
        logic [1:0]  cmd;
        route_t      op;
        logic        typed;
        reply_t      want;
    } step_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // cmd[1:0], dest_addr[33:2], route_netmask[65:34],
                             // hop_addr[97:66], zero pad[103:98]
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;   // status[2:0], route_found[3], forward_addr[35:4],
                             // zero pad[39:36]
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // Predictor state: interface registers and the user route table
    logic [31:0] port_a_ip, port_a_mask, port_b_ip, port_b_mask;
    logic [31:0] fib_mask [TABLE_DEPTH];
    logic [31:0] fib_dest [TABLE_DEPTH];
    logic [31:0] fib_hop  [TABLE_DEPTH];
    int          fib_count;

    reply_t pending_replies[$];
    step_t  steps[$];
    int     mismatch_count;
    bit     quiet;

    route_table_prefix_match_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] prefix_mask(int unsigned len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // Route in table order: 0 and 1 are the interface direct routes
    function automatic route_t table_route(int idx);
        route_t r;
        if (idx == 0) begin
            r.mask = port_a_mask;
            r.dest = port_a_ip & port_a_mask;
            r.hop  = '0;
        end else if (idx == 1) begin
            r.mask = port_b_mask;
            r.dest = port_b_ip & port_b_mask;
            r.hop  = '0;
        end else begin
            r.mask = fib_mask[idx - 2];
            r.dest = fib_dest[idx - 2];
            r.hop  = fib_hop[idx - 2];
        end
        return r;
    endfunction

    // Executes one command on the predictor table and returns its result
    function automatic reply_t apply_route_cmd(logic [1:0] cmd, route_t op);
        reply_t      rsp;
        route_t      r;
        logic [31:0] best;
        logic        dup;
        int          i;
        int          k;
        rsp  = '0;
        best = '0;
        dup  = 1'b0;
        case (cmd)
            CMD_LOOKUP: begin
                // Longest mask wins; >= lets a later route take a tie
                for (i = 0; i < 2 + fib_count; i++) begin
                    r = table_route(i);
                    if ((op.dest & r.mask) == r.dest && (!rsp.found || r.mask >= best)) begin
                        rsp.found = 1'b1;
                        best      = r.mask;
                        rsp.fwd   = (r.hop == '0) ? op.dest : r.hop;
                    end
                end
                rsp.status = STAT_OK;
            end
            CMD_ADD: begin
                for (i = 0; i < 2 + fib_count; i++) begin
                    r = table_route(i);
                    if (r.mask == op.mask && r.dest == op.dest && r.hop == op.hop) dup = 1'b1;
                end
                if (dup) begin
                    rsp.status = STAT_DUP;
                end else if ((port_a_mask & op.hop) != (port_a_mask & port_a_ip) &&
                             (port_b_mask & op.hop) != (port_b_mask & port_b_ip)) begin
                    rsp.status = STAT_UNREACH;
                end else if (fib_count >= TABLE_DEPTH) begin
                    rsp.status = STAT_FULL;
                end else begin
                    fib_mask[fib_count] = op.mask;
                    fib_dest[fib_count] = op.dest;
                    fib_hop[fib_count]  = op.hop;
                    fib_count++;
                    rsp.status = STAT_OK;
                end
            end
            CMD_DELETE: begin
                if (op.hop == '0) begin
                    rsp.status = STAT_DIRECT;
                end else begin
                    rsp.status = STAT_NOTFOUND;
                    k = -1;
                    for (i = 0; i < fib_count; i++) begin
                        if (k < 0 && fib_mask[i] == op.mask && fib_dest[i] == op.dest &&
                            fib_hop[i] == op.hop) k = i;
                    end
                    if (k >= 0) begin
                        // close the gap, later entries keep their order
                        for (i = k; i + 1 < fib_count; i++) begin
                            fib_mask[i] = fib_mask[i + 1];
                            fib_dest[i] = fib_dest[i + 1];
                            fib_hop[i]  = fib_hop[i + 1];
                        end
                        fib_count--;
                        rsp.status = STAT_OK;
                    end
                end
            end
            default: rsp = '0;
        endcase
        return rsp;
    endfunction

    function automatic step_t item_row(logic [1:0] cmd, logic [31:0] dest, logic [31:0] mask,
                                       logic [31:0] hop);
        step_t s;
        s.is_cfg  = 1'b0;
        s.cfg_idx = '0;
        s.cfg_val = '0;
        s.cmd     = cmd;
        s.op.dest = dest;
        s.op.mask = mask;
        s.op.hop  = hop;
        s.typed   = 1'b0;
        s.want    = '0;
        return s;
    endfunction

    function automatic step_t known_row(logic [1:0] cmd, logic [31:0] dest, logic [31:0] mask,
                                        logic [31:0] hop, logic [2:0] status, logic found,
                                        logic [31:0] fwd);
        step_t s;
        s       = item_row(cmd, dest, mask, hop);
        s.typed = 1'b1;
        s.want  = '{status: status, found: found, fwd: fwd};
        return s;
    endfunction

    function automatic step_t cfg_row(logic [1:0] idx, logic [31:0] val);
        step_t s;
        s         = item_row(CMD_NONE, '0, '0, '0);
        s.is_cfg  = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        return s;
    endfunction

    // Appends one row to the directed table
    function automatic void add_step(step_t s);
        steps.insert(steps.size(), s);
    endfunction

    // Random command, mostly aimed at routes that are in the table
    function automatic void pick_random_cmd(output logic [1:0] cmd, output route_t op);
        int unsigned sel;
        route_t      r;
        sel     = $urandom_range(0, 99);
        op.mask = $urandom;
        op.dest = $urandom;
        op.hop  = $urandom;
        if (sel < 40)      cmd = CMD_LOOKUP;
        else if (sel < 75) cmd = CMD_ADD;
        else if (sel < 95) cmd = CMD_DELETE;
        else               cmd = CMD_NONE;
        r = table_route($urandom_range(0, 1 + fib_count));
        case (cmd)
            CMD_LOOKUP: begin
                sel = $urandom_range(0, 9);
                if (sel == 0)     op.dest = '0;
                else if (sel == 1) op.dest = '1;
                else if (sel < 8) op.dest = r.dest | (op.dest & ~r.mask);
            end
            CMD_ADD: begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    op = r;     // duplicate of a live route
                end else begin
                    if (sel < 4) begin
                        // same prefix, new hop: tie candidate
                        op.mask = r.mask;
                        op.dest = r.dest;
                    end else if (sel < 9) begin
                        op.mask = prefix_mask($urandom_range(0, 32));
                        op.dest = op.dest & op.mask;
                    end else begin
                        op.mask = prefix_mask($urandom_range(0, 32));
                    end
                    sel = $urandom_range(0, 9);
                    if (sel < 3)      op.hop = (port_a_ip & port_a_mask) | (op.hop & ~port_a_mask);
                    else if (sel < 6) op.hop = (port_b_ip & port_b_mask) | (op.hop & ~port_b_mask);
                    else if (sel == 6) op.hop = '0;
                end
            end
            CMD_DELETE: begin
                sel = $urandom_range(0, 9);
                if (fib_count > 0 && sel < 7) begin
                    op = table_route(2 + $urandom_range(0, fib_count - 1));
                    if (sel == 6) op.hop = op.hop ^ 32'h1;  // near miss
                end else if (sel == 7) begin
                    op.hop = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // Drives one command and records its expected result on acceptance
    task automatic send_cmd(input logic [1:0] cmd, input route_t op, input logic typed,
                            input reply_t want);
        reply_t rsp;
        cfg_valid <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, op.hop, op.mask, op.dest, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rsp = apply_route_cmd(cmd, op);
        if (typed) rsp = want;
        pending_replies.insert(pending_replies.size(), rsp);
    endtask

    // Register write, issued only once every outstanding result has come back
    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_PORT_A_ADDR:    port_a_ip   = val;
            CFG_PORT_A_NETMASK: port_a_mask = val;
            CFG_PORT_B_ADDR:    port_b_ip   = val;
            default:            port_b_mask = val;
        endcase
    endtask

    // Result side: check each transfer, then pick the next ready with random stalls
    initial begin
        reply_t got;
        reply_t exp;
        int     hold_off;
        hold_off = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.found  = m_tdata[3];
                got.fwd    = m_tdata[35:4];
                if (pending_replies.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    exp = pending_replies.pop_front();
                    if (got.status !== exp.status) begin
                        $error("status: expected %0d, actual %0d", exp.status, got.status);
                        mismatch_count++;
                    end
                    if (got.found !== exp.found) begin
                        $error("route_found: expected %0d, actual %0d", exp.found, got.found);
                        mismatch_count++;
                    end
                    if (got.fwd !== exp.fwd) begin
                        $error("forward_addr: expected %h, actual %h", exp.fwd, got.fwd);
                        mismatch_count++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold_off = $urandom_range(1, 6) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer on any channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Main stimulus
    initial begin
        logic [1:0]  cmd;
        route_t      op;
        int          phase;
        int          n;
        logic [31:0] a_ip, a_m, b_ip, b_m;

        mismatch_count = 0;
        quiet          = 1'b0;
        port_a_ip      = '0;
        port_a_mask    = '0;
        port_b_ip      = '0;
        port_b_mask    = '0;
        fib_count      = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // Reset-value registers: both direct routes match everything
        add_step(known_row(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, STAT_OK, 1'b1, 32'h0));
        add_step(known_row(CMD_LOOKUP, '1, '1, '1, STAT_OK, 1'b1, '1));
        add_step(known_row(CMD_NONE, '1, '1, '1, STAT_OK, 1'b0, 32'h0));
        // identical to a direct route
        add_step(known_row(CMD_ADD, 32'h0, 32'h0, 32'h0, STAT_DUP, 1'b0, 32'h0));
        add_step(known_row(CMD_DELETE, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
                           STAT_DIRECT, 1'b0, 32'h0));
        add_step(known_row(CMD_DELETE, 32'h0A00_0000, 32'hFF00_0000, 32'h1,
                           STAT_NOTFOUND, 1'b0, 32'h0));
        add_step(known_row(CMD_ADD, '1, '1, 32'h1234_5678, STAT_OK, 1'b0, 32'h0));
        add_step(item_row(CMD_LOOKUP, '1, 32'h0, 32'h0));
        // zero hop user route acts as direct
        add_step(known_row(CMD_ADD, 32'h0A0B_0000, 32'hFFFF_0000, 32'h0,
                           STAT_OK, 1'b0, 32'h0));
        add_step(item_row(CMD_LOOKUP, 32'h0A0B_1234, 32'h0, 32'h0));
        // same prefix later in the table takes the tie
        add_step(known_row(CMD_ADD, 32'h0A0B_0000, 32'hFFFF_0000, 32'h0B00_0001,
                           STAT_OK, 1'b0, 32'h0));
        add_step(item_row(CMD_LOOKUP, 32'h0A0B_5555, 32'h0, 32'h0));
        add_step(known_row(CMD_ADD, 32'h0A0B_0000, 32'hFFFF_0000, 32'h0B00_0001,
                           STAT_DUP, 1'b0, 32'h0));
        // destination stored unmasked never matches
        add_step(known_row(CMD_ADD, 32'h0A0B_0C0D, 32'hFFFF_FF00, 32'h1,
                           STAT_OK, 1'b0, 32'h0));
        add_step(item_row(CMD_LOOKUP, 32'h0A0B_0C0D, 32'h0, 32'h0));
        add_step(known_row(CMD_DELETE, 32'h0A0B_0000, 32'hFFFF_0000, 32'h0B00_0001,
                           STAT_OK, 1'b0, 32'h0));
        add_step(item_row(CMD_LOOKUP, 32'h0A0B_5555, 32'h0, 32'h0));
        add_step(known_row(CMD_DELETE, 32'h0A0B_0000, 32'hFFFF_0000, 32'h0B00_0001,
                           STAT_NOTFOUND, 1'b0, 32'h0));
        // removing the first entry shifts the rest up
        add_step(known_row(CMD_DELETE, '1, '1, 32'h1234_5678, STAT_OK, 1'b0, 32'h0));
        add_step(item_row(CMD_LOOKUP, '1, 32'h0, 32'h0));
        // Real interface subnets
        add_step(cfg_row(CFG_PORT_A_ADDR, 32'hC0A8_0001));
        add_step(cfg_row(CFG_PORT_A_NETMASK, 32'hFFFF_FF00));
        add_step(cfg_row(CFG_PORT_B_ADDR, 32'h0A00_0001));
        add_step(cfg_row(CFG_PORT_B_NETMASK, 32'hFF00_0000));
        add_step(known_row(CMD_ADD, 32'h2000_0000, 32'hFFFF_0000, 32'h5500_0000,
                           STAT_UNREACH, 1'b0, 32'h0));
        add_step(item_row(CMD_ADD, 32'h2000_0000, 32'hFFFF_0000, 32'hC0A8_00FE));
        add_step(item_row(CMD_LOOKUP, 32'h2000_1234, 32'h0, 32'h0));
        add_step(item_row(CMD_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0));
        add_step(known_row(CMD_LOOKUP, 32'h0102_0304, 32'h0, 32'h0,
                           STAT_OK, 1'b0, 32'h0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (steps[i]) begin
            if (steps[i].is_cfg) write_cfg(steps[i].cfg_idx, steps[i].cfg_val);
            else send_cmd(steps[i].cmd, steps[i].op, steps[i].typed, steps[i].want);
        end

        // Random phases, each under its own interface setting
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1) quiet = 1'b1;
            a_ip = $urandom;
            b_ip = $urandom;
            case (phase)
                0: begin
                    a_ip = '0; a_m = '0; b_ip = '0; b_m = '0;
                end
                1: begin
                    a_ip = '1; a_m = '1; b_ip = '1; b_m = '1;
                end
                2: begin
                    a_m = '1; b_m = '0;
                end
                default: begin
                    if (phase % 3 == 0) begin
                        a_m = $urandom;
                        b_m = $urandom;
                    end else begin
                        a_m = prefix_mask($urandom_range(0, 32));
                        b_m = prefix_mask($urandom_range(0, 32));
                    end
                end
            endcase
            write_cfg(CFG_PORT_A_ADDR, a_ip);
            write_cfg(CFG_PORT_A_NETMASK, a_m);
            write_cfg(CFG_PORT_B_ADDR, b_ip);
            write_cfg(CFG_PORT_B_NETMASK, b_m);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick_random_cmd(cmd, op);
                send_cmd(cmd, op, 1'b0, '0);
            end
        end
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;

        // Drain, then allow for stray results
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
